// File: sv/cft_pkg.sv
`timescale 1ns / 1ps

package cft_pkg;

    // Result kinds
    localparam logic [1:0] KIND_CHAR      = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_RESULT    = 2'd2;

    // Frame status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_CLOSE = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // Command ids
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_PRINT    = 2'd1;
    localparam logic [1:0] CMD_SHOWTIME = 2'd2;
    localparam logic [1:0] CMD_HELP     = 2'd3;

    // Actions
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_RUN    = 2'd1;
    localparam logic [1:0] ACT_REJECT = 2'd2;

    // Delimiters and printable range
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_PRINT_LO   = 8'd32;
    localparam logic [7:0] CH_PRINT_HI   = 8'd126;

    // Command name lengths
    localparam logic [7:0] PRINT_LEN    = 8'd5;
    localparam logic [7:0] SHOWTIME_LEN = 8'd8;
    localparam logic [7:0] HELP_LEN     = 8'd4;

    typedef enum logic [1:0] {
        PH_NAME,
        PH_ARGS,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_SKIP,
        EV_CHAR,
        EV_NAME_END,
        EV_TOKEN_END,
        EV_CLOSE,
        EV_SLOTS_FULL,
        EV_TOO_LONG
    } event_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] token_index;
        logic [4:0] char_pos;
        logic [6:0] char_value;
        logic [1:0] status;
        logic [2:0] token_count;
        logic [1:0] cmd_id;
        logic [1:0] action;
    } res_t;

    function automatic logic [7:0] print_char(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = "p";
            3'd1:    ch = "r";
            3'd2:    ch = "i";
            3'd3:    ch = "n";
            3'd4:    ch = "t";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] showtime_char(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = "s";
            3'd1:    ch = "h";
            3'd2:    ch = "o";
            3'd3:    ch = "w";
            3'd4:    ch = "t";
            3'd5:    ch = "i";
            3'd6:    ch = "m";
            3'd7:    ch = "e";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] help_char(input logic [2:0] i);
        logic [7:0] ch;
        case (i)
            3'd0:    ch = "h";
            3'd1:    ch = "e";
            3'd2:    ch = "l";
            3'd3:    ch = "p";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Bit per candidate: {help, showtime, print} still agrees at this position
    function automatic logic [2:0] name_hits(input logic [7:0] pos, input logic [7:0] c);
        logic [2:0] hits;
        hits[0] = (pos < PRINT_LEN)    && (print_char(pos[2:0]) == c);
        hits[1] = (pos < SHOWTIME_LEN) && (showtime_char(pos[2:0]) == c);
        hits[2] = (pos < HELP_LEN)     && (help_char(pos[2:0]) == c);
        return hits;
    endfunction

    function automatic logic [2:0] name_len_hits(input logic [7:0] len);
        return {len == HELP_LEN, len == SHOWTIME_LEN, len == PRINT_LEN};
    endfunction

    function automatic logic [1:0] match_id(input logic [2:0] m);
        logic [1:0] id;
        if (m[0])
            id = CMD_PRINT;
        else if (m[1])
            id = CMD_SHOWTIME;
        else if (m[2])
            id = CMD_HELP;
        else
            id = CMD_NONE;
        return id;
    endfunction

endpackage

// File: sv/cft_in_if.sv
`timescale 1ns / 1ps

interface cft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// File: sv/cft_out_if.sv
`timescale 1ns / 1ps

interface cft_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [1:0] token_index;
    logic [4:0] char_pos;
    logic [6:0] char_value;
    logic [1:0] status;
    logic [2:0] token_count;
    logic [1:0] cmd_id;
    logic [1:0] action;

    modport source (
        output valid, output kind, output token_index, output char_pos,
        output char_value, output status, output token_count, output cmd_id,
        output action, input ready
    );
    modport sink (
        input valid, input kind, input token_index, input char_pos,
        input char_value, input status, input token_count, input cmd_id,
        input action, output ready
    );
endinterface

// File: sv/command_frame_tokenizer.sv
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register; when the parser takes it, its result,
//   if any, is loaded into the result register, which drives results.valid.
// Throughput: one byte per cycle while the result register is empty or ready is high; any
//   byte, with or without a result, waits in the input register while a result is held.
// Reset: rst_n asynchronous active low; clears both stages and parser state.
module command_frame_tokenizer #(
    parameter int MAX_ARGS      = 4,
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    cft_in_if.sink      bytes,
    cft_out_if.source   results
);
    import cft_pkg::*;

    // Input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eob_reg;

    // Result stage
    logic       out_valid_reg, out_valid_next;
    res_t       out_res_reg;

    logic       proc;
    logic       res_valid;
    res_t       res;

    // The parser advances when its result (if any) has a free slot downstream.
    assign proc        = s1_valid_reg && (!out_valid_reg || results.ready);
    assign bytes.ready = !s1_valid_reg || proc;

    cft_parser #(
        .MAX_ARGS      (MAX_ARGS),
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (proc),
        .data_byte     (s1_byte_reg),
        .end_of_buffer (s1_eob_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (bytes.ready)
            s1_valid_reg <= bytes.valid;
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            s1_byte_reg <= bytes.data_byte;
            s1_eob_reg  <= bytes.end_of_buffer;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc && res_valid)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (proc && res_valid)
            out_res_reg <= res;
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = out_res_reg.kind;
    assign results.token_index = out_res_reg.token_index;
    assign results.char_pos    = out_res_reg.char_pos;
    assign results.char_value  = out_res_reg.char_value;
    assign results.status      = out_res_reg.status;
    assign results.token_count = out_res_reg.token_count;
    assign results.cmd_id      = out_res_reg.cmd_id;
    assign results.action      = out_res_reg.action;

endmodule

// File: sv/cft_parser.sv
`timescale 1ns / 1ps

module cft_parser #(
    parameter int MAX_ARGS      = 4,
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [7:0]    data_byte,
    input  logic          end_of_buffer,
    output logic          res_valid,
    output cft_pkg::res_t res
);
    import cft_pkg::*;

    localparam int TNW = $clog2(MAX_ARGS);
    localparam int CCW = $clog2(MAX_TOKEN_LEN);
    localparam logic [TNW-1:0] TN_LAST = TNW'(MAX_ARGS - 1);
    localparam logic [CCW-1:0] CC_LAST = CCW'(MAX_TOKEN_LEN - 1);
    localparam logic [2:0]     SLOTS_COUNT = 3'(MAX_ARGS - 1);

    phase_t         phase_reg, phase_next;
    logic           skip_reg, skip_next;
    logic [TNW-1:0] tn_reg, tn_next;
    logic [CCW-1:0] cc_reg, cc_next;
    logic [2:0]     match_reg, match_next;

    event_t         ev;
    logic           printable;
    logic           finished;
    logic           early_end;
    logic [7:0]     cc8;
    logic [31:0]    cc_wide;
    logic [31:0]    tn_wide;
    logic [TNW:0]   tn_plus;

    assign printable = data_byte inside {[CH_PRINT_LO:CH_PRINT_HI]};
    assign cc8       = 8'(cc_reg);
    assign cc_wide   = 32'(cc_reg);
    assign tn_wide   = 32'(tn_reg);
    assign tn_plus   = {1'b0, tn_reg} + {{TNW{1'b0}}, 1'b1};

    // Classify the byte against the current state
    always_comb
    begin
        ev = EV_NONE;
        if (phase_reg == PH_DONE)
            ev = EV_NONE;
        else if (skip_reg)
            ev = EV_SKIP;
        else if (cc_reg >= CC_LAST)
            ev = EV_TOO_LONG;
        else if (phase_reg == PH_NAME)
        begin
            if (!printable)
                ev = EV_NONE;
            else if (data_byte == CH_LBRACK)
                ev = EV_NAME_END;
            else
                ev = EV_CHAR;
        end
        else
        begin
            if (data_byte == CH_RBRACK)
                ev = EV_CLOSE;
            else if (!printable)
                ev = EV_NONE;
            else if (data_byte == CH_SEMI)
                ev = (tn_reg >= TN_LAST) ? EV_SLOTS_FULL : EV_TOKEN_END;
            else
                ev = EV_CHAR;
        end
    end

    assign finished  = (ev == EV_CLOSE) || (ev == EV_SLOTS_FULL) || (ev == EV_TOO_LONG);
    assign early_end = end_of_buffer && !finished && (phase_reg != PH_DONE);

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        tn_next    = tn_reg;
        cc_next    = cc_reg;
        match_next = match_reg;
        case (ev)
            EV_SKIP:
                skip_next = 1'b0;
            EV_CHAR:
            begin
                cc_next = cc_reg + 1'b1;
                if (phase_reg == PH_NAME)
                    match_next = match_reg & name_hits(cc8, data_byte);
            end
            EV_NAME_END:
            begin
                match_next = match_reg & name_len_hits(cc8);
                phase_next = PH_ARGS;
                tn_next    = TNW'(1);
                cc_next    = '0;
                skip_next  = 1'b1;
            end
            EV_TOKEN_END:
            begin
                tn_next = tn_reg + 1'b1;
                cc_next = '0;
            end
            EV_CLOSE, EV_SLOTS_FULL, EV_TOO_LONG:
                phase_next = PH_DONE;
            default:
                phase_next = phase_reg;
        endcase
        // end of buffer always returns to the idle frame state
        if (end_of_buffer)
        begin
            phase_next = PH_NAME;
            skip_next  = 1'b0;
            tn_next    = '0;
            cc_next    = '0;
            match_next = 3'b111;
        end
    end

    // Result
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        if (early_end)
        begin
            res_valid  = 1'b1;
            res.kind   = KIND_RESULT;
            res.status = ST_NO_CLOSE;
            res.action = ACT_REJECT;
        end
        else
        begin
            case (ev)
                EV_CHAR:
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_CHAR;
                    res.token_index  = tn_wide[1:0];
                    res.char_pos     = cc_wide[4:0];
                    res.char_value   = data_byte[6:0];
                end
                EV_NAME_END, EV_TOKEN_END:
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_TOKEN_END;
                    res.token_index  = tn_wide[1:0];
                    res.char_pos     = cc_wide[4:0];
                end
                EV_CLOSE, EV_SLOTS_FULL:
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_RESULT;
                    res.status       = ST_OK;
                    res.token_count  = (ev == EV_CLOSE) ? 3'(32'(tn_plus)) : SLOTS_COUNT;
                    res.cmd_id       = match_id(match_reg);
                    res.action       = (match_id(match_reg) != CMD_NONE) ? ACT_RUN : ACT_NONE;
                end
                EV_TOO_LONG:
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_RESULT;
                    res.status       = ST_TOO_LONG;
                    res.action       = ACT_REJECT;
                end
                default:
                    res_valid = 1'b0;
            endcase
        end
        if (!en)
            res_valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NAME;
            skip_reg  <= 1'b0;
            tn_reg    <= '0;
            cc_reg    <= '0;
            match_reg <= 3'b111;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            skip_reg  <= skip_next;
            tn_reg    <= tn_next;
            cc_reg    <= cc_next;
            match_reg <= match_next;
        end
    end

`ifndef SYNTH
    a_skip_in_args: assert property (@(posedge clk) disable iff (!rst_n)
        skip_reg |-> (phase_reg == PH_ARGS))
        else $error("skip pending outside argument phase");

    a_cc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cc_reg <= CC_LAST)
        else $error("character count past token limit");

    a_name_token_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_NAME) |-> (tn_reg == '0))
        else $error("nonzero token number in name phase");

    a_eob_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (en && end_of_buffer) |=> (phase_reg == PH_NAME) && !skip_reg
                                  && (cc_reg == '0) && (match_reg == 3'b111))
        else $error("end of buffer did not restore frame state");
`endif

endmodule

// File: test/cft_frame_checker.sv
`timescale 1ns / 1ps

module cft_frame_checker #(
    parameter int MAX_ARGS      = 4,
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic clk,
    input  logic rst_n,
    cft_in_if    bytes,
    cft_out_if   results,
    output int   fail_count,
    output int   pending
);
    import cft_pkg::*;

    localparam int MAX_PRINTED = 50;

    string cand_names[3] = '{"print", "showtime", "help"};

    // tokenizer state
    phase_t     frame_phase;
    bit         skip_next;
    int         tok_num;
    int         tok_len;
    logic [2:0] cand_alive;   // {help, showtime, print} still possible

    res_t expected_q[$];
    int   err_total = 0;
    int   results_seen = 0;

    assign fail_count = err_total;

    task automatic report_mismatch(input string msg);
        err_total++;
        if (err_total <= MAX_PRINTED)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic clear_tokenizer();
        frame_phase = PH_NAME;
        skip_next   = 1'b0;
        tok_num     = 0;
        tok_len     = 0;
        cand_alive  = 3'b111;
    endtask

    function automatic res_t frame_result(input logic [1:0] st, input int cnt);
        res_t       r;
        logic [1:0] id;
        r        = '0;
        r.kind   = KIND_RESULT;
        r.status = st;
        if (st == ST_OK)
        begin
            if (cand_alive[0])
                id = CMD_PRINT;
            else if (cand_alive[1])
                id = CMD_SHOWTIME;
            else if (cand_alive[2])
                id = CMD_HELP;
            else
                id = CMD_NONE;
            r.token_count = cnt[2:0];
            r.cmd_id      = id;
            r.action      = (id != CMD_NONE) ? ACT_RUN : ACT_NONE;
        end
        else
            r.action = ACT_REJECT;
        frame_phase = PH_DONE;
        return r;
    endfunction

    // Advance the tokenizer by one byte, queue the result it gives, if any.
    task automatic tokenize_byte(input logic [7:0] c, input logic eob);
        res_t  r;
        bit    hit;
        bit    printable;
        string nm;
        r         = '0;
        hit       = 1'b0;
        printable = (c >= CH_PRINT_LO) && (c <= CH_PRINT_HI);
        if (frame_phase == PH_DONE)
        begin
            // ignored up to the end of the buffer
        end
        else if (skip_next)
            skip_next = 1'b0;
        else if (tok_len >= MAX_TOKEN_LEN - 1)
        begin
            r   = frame_result(ST_TOO_LONG, 0);
            hit = 1'b1;
        end
        else if (frame_phase == PH_NAME)
        begin
            if (printable && c == CH_LBRACK)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    nm = cand_names[k];
                    if (tok_len != nm.len())
                        cand_alive[k] = 1'b0;
                end
                r.kind      = KIND_TOKEN_END;
                r.char_pos  = tok_len[4:0];
                hit         = 1'b1;
                frame_phase = PH_ARGS;
                tok_num     = 1;
                tok_len     = 0;
                skip_next   = 1'b1;
            end
            else if (printable)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    nm = cand_names[k];
                    if (tok_len >= nm.len() || nm[tok_len] != c)
                        cand_alive[k] = 1'b0;
                end
                r.kind       = KIND_CHAR;
                r.char_pos   = tok_len[4:0];
                r.char_value = c[6:0];
                hit          = 1'b1;
                tok_len++;
            end
        end
        else
        begin
            if (c == CH_RBRACK)
            begin
                r   = frame_result(ST_OK, tok_num + 1);
                hit = 1'b1;
            end
            else if (printable && c == CH_SEMI)
            begin
                hit = 1'b1;
                if (tok_num >= MAX_ARGS - 1)
                    r = frame_result(ST_OK, MAX_ARGS - 1);
                else
                begin
                    r.kind        = KIND_TOKEN_END;
                    r.token_index = tok_num[1:0];
                    r.char_pos    = tok_len[4:0];
                    tok_num++;
                    tok_len = 0;
                end
            end
            else if (printable)
            begin
                r.kind        = KIND_CHAR;
                r.token_index = tok_num[1:0];
                r.char_pos    = tok_len[4:0];
                r.char_value  = c[6:0];
                hit           = 1'b1;
                tok_len++;
            end
        end
        // end of buffer overrides whatever the byte produced, unless the byte ended the frame
        if (eob)
        begin
            if (frame_phase != PH_DONE)
            begin
                r   = frame_result(ST_NO_CLOSE, 0);
                hit = 1'b1;
            end
            clear_tokenizer();
        end
        if (hit)
            expected_q.push_back(r);
    endtask

    task automatic check_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, field, got, want));
    endtask

    task automatic compare_result(input res_t got, input res_t want);
        check_field("kind", got.kind, want.kind);
        check_field("token_index", got.token_index, want.token_index);
        check_field("char_pos", got.char_pos, want.char_pos);
        check_field("char_value", got.char_value, want.char_value);
        check_field("status", got.status, want.status);
        check_field("token_count", got.token_count, want.token_count);
        check_field("cmd_id", got.cmd_id, want.cmd_id);
        check_field("action", got.action, want.action);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t got;
        if (!rst_n)
        begin
            clear_tokenizer();
            expected_q.delete();
            pending <= 0;
        end
        else
        begin
            if (bytes.valid && bytes.ready)
                tokenize_byte(bytes.data_byte, bytes.end_of_buffer);
            if (results.valid && results.ready)
            begin
                results_seen++;
                got = {results.kind, results.token_index, results.char_pos,
                       results.char_value, results.status, results.token_count,
                       results.cmd_id, results.action};
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                else
                    compare_result(got, expected_q.pop_front());
            end
            pending <= expected_q.size();
        end
    end

endmodule

// File: test/command_frame_tokenizer_tb.sv
`timescale 1ns / 1ps

module command_frame_tokenizer_tb;
    import cft_pkg::*;

    localparam int MAX_ARGS      = 4;
    localparam int MAX_TOKEN_LEN = 32;
    localparam int RANDOM_BYTES  = 1450;   // stimulus stops once this many bytes went in
    localparam int LONG_HOLD     = 400;    // cycles the result side holds off when asked
    localparam int DRAIN_CYCLES  = 20;     // margin for stray results after draining

    localparam logic [7:0] CH_EQUALS = 8'h3D;

    // Shapes of random buffers
    typedef enum int {
        FRM_CLEAN,      // name[=args] closed properly
        FRM_OPEN,       // buffer ends before ']'
        FRM_LONG,       // one token is sized around the length limit
        FRM_OVERFLOW,   // more arguments than slots
        FRM_NOISE       // raw bytes of any value
    } frame_kind_t;

    logic clk;
    logic rst_n;

    cft_in_if  bytes_ch();
    cft_out_if results_ch();

    int fail_count;
    int pending;

    bit hold_request;   // stimulus asks the result side for a long hold-off
    bit src_steady;     // no gaps between bytes of the current buffer
    int sent_bytes;

    logic [7:0] frame_q[$];   // bytes of the buffer being built
    string      cmd_words[3] = '{"print", "showtime", "help"};

    command_frame_tokenizer #(
        .MAX_ARGS(MAX_ARGS),
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .bytes(bytes_ch),
        .results(results_ch)
    );

    cft_frame_checker #(
        .MAX_ARGS(MAX_ARGS),
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) frame_chk (
        .clk(clk),
        .rst_n(rst_n),
        .bytes(bytes_ch),
        .results(results_ch),
        .fail_count(fail_count),
        .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Printable character that is not a delimiter where it lands.
    // In the name only '[' matters; ']' and ';' are plain characters there.
    function automatic logic [7:0] text_char(input bit in_name);
        logic [7:0] c;
        do
            c = 8'($urandom_range(32, 126));
        while (in_name ? (c == CH_LBRACK) : (c == CH_RBRACK || c == CH_SEMI));
        return c;
    endfunction

    // Control codes, DEL and the upper half, all dropped by the block
    function automatic logic [7:0] noise_char();
        if ($urandom_range(0, 1) != 0)
            return 8'($urandom_range(0, 31));
        else
            return 8'($urandom_range(127, 255));
    endfunction

    // Append a byte, sometimes preceded by a dropped byte
    task automatic add_byte(input logic [7:0] c);
        if ($urandom_range(0, 99) < 8)
            frame_q.push_back(noise_char());
        frame_q.push_back(c);
    endtask

    task automatic add_text(input int len, input bit in_name);
        repeat (len)
            add_byte(text_char(in_name));
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++)
            frame_q.push_back(s[k]);
    endtask

    // Build one random buffer into frame_q. Most are well formed so the
    // argument phase and the name match get exercised; the rest break it.
    task automatic build_frame();
        frame_kind_t shape;
        int          pick;
        int          nargs;
        int          oversize;
        int          len;
        string       word;
        pick = $urandom_range(0, 99);
        if (pick < 68)
            shape = FRM_CLEAN;
        else if (pick < 78)
            shape = FRM_OPEN;
        else if (pick < 86)
            shape = FRM_LONG;
        else if (pick < 94)
            shape = FRM_OVERFLOW;
        else
            shape = FRM_NOISE;

        if (shape == FRM_NOISE)
        begin
            repeat ($urandom_range(1, 6))
                frame_q.push_back(8'($urandom_range(0, 255)));
            return;
        end

        nargs = (shape == FRM_OVERFLOW) ? $urandom_range(MAX_ARGS, MAX_ARGS + 1)
                                        : $urandom_range(0, MAX_ARGS - 1);
        // token 0 is the name; -1 means no token is oversized
        oversize = (shape == FRM_LONG) ? $urandom_range(0, nargs) : -1;

        // Name: a command word, a near miss of one, or random text
        if (oversize == 0)
            add_text($urandom_range(MAX_TOKEN_LEN - 2, MAX_TOKEN_LEN + 4), 1'b1);
        else
        begin
            word = cmd_words[$urandom_range(0, 2)];
            case ($urandom_range(0, 7))
                4:       word = word.substr(0, word.len() - 2);
                5:       word = $sformatf("%s%c", word, text_char(1'b1));
                6:       word[$urandom_range(0, word.len() - 1)] = text_char(1'b1);
                7:       word = "";
                default: ;   // exact command word
            endcase
            if (word.len() == 0)
                add_text($urandom_range(0, 8), 1'b1);
            else
                for (int k = 0; k < word.len(); k++)
                    add_byte(word[k]);
        end

        add_byte(CH_LBRACK);
        // byte after '[' is skipped whatever it is, so anything goes there
        frame_q.push_back(($urandom_range(0, 2) != 0) ? CH_EQUALS
                                                     : 8'($urandom_range(0, 255)));

        for (int a = 1; a <= nargs; a++)
        begin
            if (a > 1)
                add_byte(CH_SEMI);
            len = (a == oversize) ? $urandom_range(MAX_TOKEN_LEN - 2, MAX_TOKEN_LEN + 4)
                                  : $urandom_range(0, 5);
            add_text(len, 1'b0);
        end

        if (shape != FRM_OPEN)
            add_byte(CH_RBRACK);
    endtask

    // Offer one byte and hold it until accepted, then maybe go idle
    task automatic send_byte(input logic [7:0] c, input logic last);
        int gap;
        bytes_ch.valid         <= 1'b1;
        bytes_ch.data_byte     <= c;
        bytes_ch.end_of_buffer <= last;
        @(posedge clk);
        while (!bytes_ch.ready)
            @(posedge clk);
        gap = src_steady ? 0 : idle_gap();
        if (gap > 0)
        begin
            bytes_ch.valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    // Send frame_q plus some junk after it; the last byte carries the
    // end-of-buffer mark. Junk after the frame is not counted.
    task automatic send_buffer(input int trail);
        sent_bytes += frame_q.size();
        repeat (trail)
            frame_q.push_back(8'($urandom_range(0, 255)));
        for (int k = 0; k < frame_q.size(); k++)
            send_byte(frame_q[k], k == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // Stop offering, let the expected-result count settle for the last
    // accepted byte, then wait until every expected item has come out
    task automatic wait_drained();
        bytes_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Result side: alternating ready/stall runs of random length, plus
    // the long hold-off on request, counted here in cycles.
    initial
    begin : result_sink
        int  run_left;
        bit  run_high;
        int  hold_left;
        run_left  = 0;
        run_high  = 1'b1;
        hold_left = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD - 1;
                results_ch.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    if (run_high)
                    begin
                        run_left = idle_gap();
                        run_high = (run_left == 0);
                        if (run_high)
                            run_left = $urandom_range(1, 40);
                    end
                    else
                    begin
                        run_high = 1'b1;
                        // occasionally a long stretch with no stalls at all
                        run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 250)
                                                                : $urandom_range(1, 40);
                    end
                end
                results_ch.ready <= run_high;
                run_left--;
            end
        end
    end

    initial
    begin : stimulus
        int frame_no;
        rst_n                  <= 1'b0;
        bytes_ch.valid         <= 1'b0;
        bytes_ch.data_byte     <= 8'h00;
        bytes_ch.end_of_buffer <= 1'b0;
        hold_request = 1'b0;
        src_steady   = 1'b0;
        sent_bytes   = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed buffers.
        // Exact command name, control byte as the skipped byte, no arguments.
        push_text("help[");
        frame_q.push_back(8'h00);
        frame_q.push_back(CH_RBRACK);
        send_buffer(0);

        // Printable extremes and ']' inside the name, dropped bytes on both
        // sides of the printable range, then every slot filled by ';' so the
        // frame ends without ']'. The trailing 0xFF is ignored.
        frame_q.push_back(CH_PRINT_LO);
        frame_q.push_back(CH_RBRACK);
        frame_q.push_back(CH_PRINT_HI);
        frame_q.push_back(8'd31);
        frame_q.push_back(8'd127);
        push_text("[x;;;");
        frame_q.push_back(8'hFF);
        send_buffer(0);

        // Buffer ends inside the name: the last char is not reported
        push_text("print");
        send_buffer(0);

        // Single dropped byte that is also the end of the buffer
        frame_q.push_back(8'h80);
        send_buffer(0);

        // Random buffers. Every so often the result side is told to hold off
        // while bytes keep coming (fills the pipe, stalls the input), and
        // the sender waits for the block to run dry.
        frame_no = 0;
        while (sent_bytes < RANDOM_BYTES)
        begin
            if (frame_no % 40 == 8)
                hold_request = 1'b1;
            if (frame_no % 40 == 28)
                wait_drained();
            src_steady = ($urandom_range(0, 3) == 0);
            build_frame();
            send_buffer($urandom_range(0, 2));
            frame_no++;
        end

        wait_drained();
        // catch anything the block emits after the last expected item
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("[command_frame_tokenizer] OK");
        else
            $display("[command_frame_tokenizer] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #15_000_000;
        $display("[command_frame_tokenizer] ERROR");
        $finish;
    end

endmodule
